FILE: rtl/core/cus_pkg.sv
// shared constants, types and the dot remap for the cell update segmenter
`default_nettype none
package cus_pkg;

   localparam int MAX_CELLS   = 128;
   localparam int GAP_LIMIT   = 8;
   localparam int GAP_HALF    = GAP_LIMIT / 2;
   localparam int IDX_W       = $clog2(MAX_CELLS);
   localparam int LEN_W       = IDX_W + 1;
   localparam int CELL_W      = 8;
   localparam int RUN_W       = 8;
   localparam int WORD_CELLS  = 8;
   localparam int SLOT_W      = $clog2(WORD_CELLS);
   localparam int WORD_W      = WORD_CELLS * CELL_W;
   localparam int WORD_LIMIT  = 16;
   localparam int WNUM_W      = 4;
   localparam int OFFSET_W    = 7;
   localparam int CELLS_W     = 8;
   localparam int COUNT_W     = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CELL_W-1:0]  CELL_RESET  = 8'hFF;
   localparam logic [RUN_W-1:0]   RUN_MAX     = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd40;

   // register index, taken from paddr[2]
   localparam logic CSR_CELL_COUNT = 1'b0;

   typedef struct packed {
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
   } seg_type;

   // dot permutation: 1->3, 2->1, 3->4, 4->2, others stay
   function automatic logic [CELL_W-1:0] remap_dots(input logic [CELL_W-1:0] p);
      logic [CELL_W-1:0] r;
      r    = p & 8'hE1;
      r[3] = p[1];
      r[1] = p[2];
      r[4] = p[3];
      r[2] = p[4];
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cus_ram.sv
// generic single write port ram with registered read
`default_nettype none
module cus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cus_packer.sv
// segment word packer: reads stored cells one at a time, remaps and packs them
`default_nettype none
module cus_packer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire cus_pkg::seg_type               seg,
   input  wire logic [cus_pkg::CELL_W-1:0]     cell_data,
   output logic      [cus_pkg::IDX_W-1:0]      rd_addr,
   output logic                                busy,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [cus_pkg::OFFSET_W-1:0]   rsp_segment_offset,
   output logic      [cus_pkg::CELLS_W-1:0]    rsp_segment_cells,
   output logic      [cus_pkg::WNUM_W-1:0]     rsp_word_number,
   output logic      [cus_pkg::WORD_W-1:0]     rsp_dots_word,
   output logic                                rsp_last_word
);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_READ = 2'd1;
   localparam logic [1:0] P_TAKE = 2'd2;
   localparam logic [1:0] P_HOLD = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [cus_pkg::IDX_W-1:0]      first_ff, first_in;
   logic [cus_pkg::IDX_W-1:0]      last_ff, last_in;
   logic [cus_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [cus_pkg::WNUM_W-1:0]     last_num_ff, last_num_in;
   logic [cus_pkg::WNUM_W-1:0]     word_num_ff, word_num_in;
   logic [cus_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [cus_pkg::LEN_W-1:0]      pos_ff, pos_in;
   logic [cus_pkg::WORD_W-1:0]     word_ff, word_in;

   logic                           out_valid_ff, out_valid_in;
   logic [cus_pkg::OFFSET_W-1:0]   out_offset_ff, out_offset_in;
   logic [cus_pkg::CELLS_W-1:0]    out_cells_ff, out_cells_in;
   logic [cus_pkg::WNUM_W-1:0]     out_wnum_ff, out_wnum_in;
   logic [cus_pkg::WORD_W-1:0]     out_word_ff, out_word_in;
   logic                           out_last_ff, out_last_in;

   logic                           in_seg;
   logic                           out_free;
   logic                           word_done;
   logic [cus_pkg::CELL_W-1:0]     cell_byte;
   logic [cus_pkg::LEN_W-1:0]      start_len;
   logic [cus_pkg::LEN_W-1:0]      words_m1;

   assign in_seg   = pos_ff <= cus_pkg::LEN_W'(last_ff);
   assign out_free = !out_valid_ff || rsp_ready;
   assign rd_addr  = pos_ff[cus_pkg::IDX_W-1:0];
   assign busy     = state_ff != P_IDLE;

   assign start_len = cus_pkg::LEN_W'(seg.last) - cus_pkg::LEN_W'(seg.first)
                      + cus_pkg::LEN_W'(1);
   assign words_m1  = (start_len - cus_pkg::LEN_W'(1)) >> cus_pkg::SLOT_W;
   assign word_done = slot_ff == cus_pkg::SLOT_W'(cus_pkg::WORD_CELLS - 1);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      len_in        = len_ff;
      last_num_in   = last_num_ff;
      word_num_in   = word_num_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_offset_in = out_offset_ff;
      out_cells_in  = out_cells_ff;
      out_wnum_in   = out_wnum_ff;
      out_word_in   = out_word_ff;
      out_last_in   = out_last_ff;
      cell_byte     = '0;

      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               first_in    = seg.first;
               last_in     = seg.last;
               len_in      = start_len;
               pos_in      = cus_pkg::LEN_W'(seg.first);
               slot_in     = '0;
               word_num_in = '0;
               if (words_m1 > cus_pkg::LEN_W'(cus_pkg::WORD_LIMIT - 1)) begin
                  last_num_in = cus_pkg::WNUM_W'(cus_pkg::WORD_LIMIT - 1);
               end else begin
                  last_num_in = cus_pkg::WNUM_W'(words_m1);
               end
               state_in = P_READ;
            end
         end
         P_READ, P_TAKE: begin
            // cells past the end of the segment shift in as zero without a read
            if (state_ff == P_READ && in_seg) begin
               state_in = P_TAKE;
            end else begin
               if (state_ff == P_TAKE) begin
                  cell_byte = cus_pkg::remap_dots(cell_data);
               end
               word_in = {cell_byte, word_ff[cus_pkg::WORD_W-1:cus_pkg::CELL_W]};
               slot_in = slot_ff + cus_pkg::SLOT_W'(1);
               pos_in  = pos_ff + cus_pkg::LEN_W'(1);
               state_in = word_done ? P_HOLD : P_READ;
            end
         end
         P_HOLD: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_offset_in = cus_pkg::OFFSET_W'(first_ff);
               out_cells_in  = cus_pkg::CELLS_W'(len_ff);
               out_wnum_in   = word_num_ff;
               out_word_in   = word_ff;
               out_last_in   = word_num_ff == last_num_ff;
               if (word_num_ff == last_num_ff) begin
                  state_in = P_IDLE;
               end else begin
                  word_num_in = word_num_ff + cus_pkg::WNUM_W'(1);
                  state_in    = P_READ;
               end
            end
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= P_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      first_ff      <= first_in;
      last_ff       <= last_in;
      len_ff        <= len_in;
      last_num_ff   <= last_num_in;
      word_num_ff   <= word_num_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      out_offset_ff <= out_offset_in;
      out_cells_ff  <= out_cells_in;
      out_wnum_ff   <= out_wnum_in;
      out_word_ff   <= out_word_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_segment_offset = out_offset_ff;
   assign rsp_segment_cells  = out_cells_ff;
   assign rsp_word_number    = out_wnum_ff;
   assign rsp_dots_word      = out_word_ff;
   assign rsp_last_word      = out_last_ff;

`ifndef NO_ASSERTIONS
   // a finished word always starts the next one at slot zero
   a_hold_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == P_HOLD |-> slot_ff == '0)
      else $error("packer word completed off slot boundary");

   // a held word moves to the output register as soon as it is free
   a_hold_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == P_HOLD && out_free) |=> out_valid_ff)
      else $error("held word not loaded into output register");

   // the word counter never runs past the last word of the segment
   a_word_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> word_num_ff <= last_num_ff)
      else $error("packer word number past last word");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/cell_update_segmenter.sv
// Cell update segmenter top level.
// Cells of a display frame enter one per transaction on req_ (valid/ready).
// Each cell is compared with the stored previous frame; changed cells are
// written back and grouped into segments, which close after more than
// GAP_LIMIT/2 unchanged cells or at the end of the frame.
// A closed segment leaves on rsp_ as one transaction per 64-bit word of
// eight remapped cells, with offset, cell count, word number and last flag.
// A cell is accepted in S_IDLE, then compared with the store and updated in S_CMP.
// A cell that closes a segment then holds req_ready low while the packer
// reads the store through its single read port: each cell inside the segment
// takes a read step and a take step, each padding slot shifts in zero without
// a read, and each finished word is then loaded into the output register.
// The output register holds a word while the receiver stalls; the packer
// waits on it, and the next cell is taken once the last word is loaded.
// Reset (synchronous, active high) clears the frame position and marks all
// store entries as 0xFF through per-entry valid bits, with no clearing pass.
// cell_count is written over the apb port at address 0; pready is always high.
`default_nettype none
module cell_update_segmenter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [cus_pkg::CELL_W-1:0]         req_cell_pattern,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [cus_pkg::OFFSET_W-1:0]       rsp_segment_offset,
   output logic      [cus_pkg::CELLS_W-1:0]        rsp_segment_cells,
   output logic      [cus_pkg::WNUM_W-1:0]         rsp_word_number,
   output logic      [cus_pkg::WORD_W-1:0]         rsp_dots_word,
   output logic                                    rsp_last_word,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cus_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [cus_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [cus_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                    pready
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_CMP  = 1'b1;
   localparam int   SUB_W  = cus_pkg::RUN_W + 1;

   logic                             state_ff, state_in;
   logic [cus_pkg::CELL_W-1:0]       pattern_ff, pattern_in;
   logic [cus_pkg::IDX_W-1:0]        cell_index_ff, cell_index_in;
   logic [cus_pkg::LEN_W-1:0]        segment_base_ff, segment_base_in;
   logic [cus_pkg::RUN_W-1:0]        same_run_ff, same_run_in;
   logic                             collecting_ff, collecting_in;
   logic [cus_pkg::COUNT_W-1:0]      cell_count_ff, cell_count_in;
   logic [cus_pkg::MAX_CELLS-1:0]    cell_vld_ff, cell_vld_in;
   logic                             vld_rd_ff;

   logic                             req_xact;
   logic                             csr_write;
   logic                             pk_busy;
   logic [cus_pkg::IDX_W-1:0]        pk_rd_addr;
   logic [cus_pkg::IDX_W-1:0]        rd_addr;
   logic [cus_pkg::CELL_W-1:0]       ram_rd_data;
   logic [cus_pkg::CELL_W-1:0]       prev_cell;
   logic                             ram_we;
   logic                             seg_start;
   cus_pkg::seg_type                 seg;
   logic [cus_pkg::RUN_W-1:0]        run_inc;
   logic [cus_pkg::LEN_W-1:0]        frame_len;
   logic                             frame_end;

   assign req_ready = state_ff == S_IDLE && !pk_busy;
   assign req_xact  = req_valid && req_ready;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && paddr[2] == cus_pkg::CSR_CELL_COUNT;
   assign prdata    = (paddr[2] == cus_pkg::CSR_CELL_COUNT) ?
                      cus_pkg::CSR_DATA_W'(cell_count_ff) : '0;

   assign rd_addr   = pk_busy ? pk_rd_addr : cell_index_ff;
   assign prev_cell = vld_rd_ff ? ram_rd_data : cus_pkg::CELL_RESET;
   assign run_inc   = (same_run_ff == cus_pkg::RUN_MAX) ? same_run_ff
                      : same_run_ff + cus_pkg::RUN_W'(1);

   // zero acts as one cell, oversize counts clip to the store depth
   always_comb begin
      priority if (cell_count_ff == '0) begin
         frame_len = cus_pkg::LEN_W'(1);
      end else if (int'(cell_count_ff) > cus_pkg::MAX_CELLS) begin
         frame_len = cus_pkg::LEN_W'(cus_pkg::MAX_CELLS);
      end else begin
         frame_len = cus_pkg::LEN_W'(cell_count_ff);
      end
   end

   assign frame_end = cus_pkg::LEN_W'(cell_index_ff) + cus_pkg::LEN_W'(1) >= frame_len;

   always_comb begin
      state_in        = state_ff;
      pattern_in      = pattern_ff;
      cell_index_in   = cell_index_ff;
      segment_base_in = segment_base_ff;
      same_run_in     = same_run_ff;
      collecting_in   = collecting_ff;
      cell_vld_in     = cell_vld_ff;
      cell_count_in   = csr_write ? pwdata[cus_pkg::COUNT_W-1:0] : cell_count_ff;
      ram_we          = 1'b0;
      seg_start       = 1'b0;
      seg.first       = cus_pkg::IDX_W'(segment_base_ff);
      seg.last        = cell_index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xact) begin
               pattern_in = req_cell_pattern;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_IDLE;
            if (pattern_ff == prev_cell) begin
               same_run_in = run_inc;
               // gap grew too long: close the open segment at its last change
               if (collecting_ff && int'(run_inc) > cus_pkg::GAP_HALF) begin
                  seg_start       = 1'b1;
                  seg.first       = cus_pkg::IDX_W'(segment_base_ff);
                  seg.last        = cus_pkg::IDX_W'(SUB_W'(cell_index_ff) - SUB_W'(run_inc));
                  segment_base_in = cus_pkg::LEN_W'(cell_index_ff);
                  collecting_in   = 1'b0;
                  same_run_in     = '0;
               end
               if (!collecting_in) begin
                  segment_base_in = segment_base_in + cus_pkg::LEN_W'(1);
               end
            end else begin
               ram_we                     = 1'b1;
               cell_vld_in[cell_index_ff] = 1'b1;
               collecting_in              = 1'b1;
               same_run_in                = '0;
            end
            if (frame_end) begin
               if (collecting_in) begin
                  seg_start = 1'b1;
                  seg.first = cus_pkg::IDX_W'(segment_base_in);
                  seg.last  = cus_pkg::IDX_W'(SUB_W'(cell_index_ff) - SUB_W'(same_run_in));
               end
               cell_index_in   = '0;
               segment_base_in = '0;
               same_run_in     = '0;
               collecting_in   = 1'b0;
            end else begin
               cell_index_in = cell_index_ff + cus_pkg::IDX_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cell_index_ff   <= '0;
         segment_base_ff <= '0;
         same_run_ff     <= '0;
         collecting_ff   <= 1'b0;
         cell_count_ff   <= cus_pkg::COUNT_RESET;
         cell_vld_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         cell_index_ff   <= cell_index_in;
         segment_base_ff <= segment_base_in;
         same_run_ff     <= same_run_in;
         collecting_ff   <= collecting_in;
         cell_count_ff   <= cell_count_in;
         cell_vld_ff     <= cell_vld_in;
      end
      pattern_ff <= pattern_in;
      vld_rd_ff  <= cell_vld_ff[rd_addr];
   end

   cus_ram #(
      .WIDTH (cus_pkg::CELL_W),
      .DEPTH (cus_pkg::MAX_CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cell_index_ff),
      .wr_data (pattern_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   cus_packer u_packer (
      .clock              (clock),
      .reset              (reset),
      .start              (seg_start),
      .seg                (seg),
      .cell_data          (prev_cell),
      .rd_addr            (pk_rd_addr),
      .busy               (pk_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_segment_offset (rsp_segment_offset),
      .rsp_segment_cells  (rsp_segment_cells),
      .rsp_word_number    (rsp_word_number),
      .rsp_dots_word      (rsp_dots_word),
      .rsp_last_word      (rsp_last_word)
   );

`ifndef NO_ASSERTIONS
   // every accepted transaction is compared in the following cycle
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      req_xact |=> state_ff == S_CMP)
      else $error("accepted cell not compared next cycle");

   // a closed segment never ends before it begins
   a_seg_order: assert property (@(posedge clock) disable iff (reset)
      seg_start |-> seg.last >= seg.first)
      else $error("segment closes before its first cell");

   // the store is never written while the packer is reading it
   a_store_quiet: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !pk_busy)
      else $error("store written during segment readout");

   // an open segment always starts behind the frame position
   a_base_behind: assert property (@(posedge clock) disable iff (reset)
      collecting_ff |-> cus_pkg::LEN_W'(cell_index_ff) > segment_base_ff)
      else $error("open segment base not behind frame position");
`endif

endmodule
`default_nettype wire
